>>> rtl/ihcc_pkg.sv
// Shared types and constants for the IPv4 header checksum checker.
package ihcc_pkg;

    // Frame layout
    localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
    localparam logic [5:0]  IP_MIN_HDR     = 6'd20;
    localparam logic [7:0]  MIN_FRAME_LEN  = 8'd34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [6:0]  CHECK_OFFSET   = 7'd10;
    localparam logic [6:0]  POS_MAX        = 7'd127;

    // Depth of the queue between parser and checksum stage
    localparam int QUEUE_DEPTH = 2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FAIL  = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    // One parsed frame, waiting for its checksum to be finished
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [5:0]  header_length;
        logic [15:0] checksum_stored;
        logic [20:0] word_sum;
        logic        truncated;
    } t_record;

    // Occupancy flags of the queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/ihcc_front.sv
// Frame parser: captures header fields and sums IPv4 header words byte by byte.
module ihcc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_frame_byte,
    input  logic             i_last_byte,
    output logic             o_wr_en,
    output ihcc_pkg::t_record o_rec
);
    import ihcc_pkg::*;

    logic [6:0]  r_pos,    n_pos;
    logic [15:0] r_type,   n_type;
    logic [5:0]  r_hlen,   n_hlen;
    logic [20:0] r_sum,    n_sum;
    logic [7:0]  r_pend,   n_pend;
    logic [15:0] r_stored, n_stored;
    logic [47:0] r_dmac,   n_dmac;
    logic [47:0] r_smac,   n_smac;
    logic [31:0] r_sip,    n_sip;
    logic [31:0] r_dip,    n_dip;

    logic [6:0] hdr_idx;
    logic [7:0] frame_len;
    logic       qualify;
    logic       truncated;

    // Field capture and header word accumulation for the current byte
    always_comb begin
        n_type   = r_type;
        n_hlen   = r_hlen;
        n_sum    = r_sum;
        n_pend   = r_pend;
        n_stored = r_stored;
        n_dmac   = r_dmac;
        n_smac   = r_smac;
        n_sip    = r_sip;
        n_dip    = r_dip;
        hdr_idx  = r_pos - ETH_HDR_LEN;

        if (r_pos < 7'd6) begin
            n_dmac = {r_dmac[39:0], i_frame_byte};
        end else if (r_pos < 7'd12) begin
            n_smac = {r_smac[39:0], i_frame_byte};
        end else if (r_pos < ETH_HDR_LEN) begin
            n_type = {r_type[7:0], i_frame_byte};
        end else begin
            if (r_pos == ETH_HDR_LEN) begin
                n_hlen = {i_frame_byte[3:0], 2'b00};
            end
            if (hdr_idx < {1'b0, n_hlen}) begin
                // Even offsets open a word, odd offsets close it; the checksum word is skipped
                if (!hdr_idx[0]) begin
                    n_pend = i_frame_byte;
                end else if (hdr_idx != CHECK_OFFSET + 7'd1) begin
                    n_sum = r_sum + {5'b0, r_pend, i_frame_byte};
                end
                if (hdr_idx == CHECK_OFFSET) begin
                    n_stored = {i_frame_byte, r_stored[7:0]};
                end else if (hdr_idx == CHECK_OFFSET + 7'd1) begin
                    n_stored = {r_stored[15:8], i_frame_byte};
                end else if (hdr_idx >= 7'd12 && hdr_idx < 7'd16) begin
                    n_sip = {r_sip[23:0], i_frame_byte};
                end else if (hdr_idx >= 7'd16 && hdr_idx < 7'd20) begin
                    n_dip = {r_dip[23:0], i_frame_byte};
                end
            end
        end

        n_pos = (r_pos != POS_MAX) ? r_pos + 7'd1 : r_pos;
    end

    // Classification at the final byte of a frame
    always_comb begin
        frame_len = {1'b0, r_pos} + 8'd1;
        qualify   = (frame_len >= MIN_FRAME_LEN) && (n_type == ETHERTYPE_IPV4)
                    && (n_hlen >= IP_MIN_HDR);
        truncated = frame_len < ({1'b0, ETH_HDR_LEN} + {2'b00, n_hlen});

        o_wr_en               = i_accept && i_last_byte && qualify;
        o_rec.dest_mac        = n_dmac;
        o_rec.source_mac      = n_smac;
        o_rec.source_ip       = n_sip;
        o_rec.dest_ip         = n_dip;
        o_rec.header_length   = n_hlen;
        o_rec.checksum_stored = n_stored;
        o_rec.word_sum        = n_sum;
        o_rec.truncated       = truncated;
    end

    // Per-frame state returns to zero after every final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos    <= '0;
            r_type   <= '0;
            r_hlen   <= '0;
            r_sum    <= '0;
            r_pend   <= '0;
            r_stored <= '0;
            r_dmac   <= '0;
            r_smac   <= '0;
            r_sip    <= '0;
            r_dip    <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_hlen   <= n_hlen;
            r_sum    <= n_sum;
            r_pend   <= n_pend;
            r_stored <= n_stored;
            r_dmac   <= n_dmac;
            r_smac   <= n_smac;
            r_sip    <= n_sip;
            r_dip    <= n_dip;
        end
    end

endmodule

>>> rtl/ihcc_queue.sv
// Short queue of parsed frames between the parser and the checksum stage.
module ihcc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  ihcc_pkg::t_record    i_wr_rec,
    input  logic                 i_rd_en,
    output ihcc_pkg::t_record    o_rd_rec,
    output ihcc_pkg::t_q_status  o_status
);
    import ihcc_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_record           r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;

    logic do_wr;
    logic do_rd;

    assign o_status.full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_wr          = i_wr_en && !o_status.full;
    assign do_rd          = i_rd_en && !o_status.empty;
    assign o_rd_rec       = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/ihcc_back.sv
// Checksum stage: folds and complements the sum, grades it and holds the result.
module ihcc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ihcc_pkg::t_record    i_rec,
    input  ihcc_pkg::t_q_status  i_q_status,
    output logic                 o_rd_en,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [47:0]          o_dest_mac,
    output logic [47:0]          o_source_mac,
    output logic [31:0]          o_source_ip,
    output logic [31:0]          o_dest_ip,
    output logic [5:0]           o_header_length,
    output logic [15:0]          o_checksum_stored,
    output logic [15:0]          o_checksum_computed,
    output logic [1:0]           o_status
);
    import ihcc_pkg::*;

    logic        r_valid;
    logic [47:0] r_dmac;
    logic [47:0] r_smac;
    logic [31:0] r_sip;
    logic [31:0] r_dip;
    logic [5:0]  r_hlen;
    logic [15:0] r_stored;
    logic [15:0] r_computed;
    logic [1:0]  r_status;

    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] computed;
    logic [1:0]  status;

    // Two end-around carry folds bring a 21-bit sum into 16 bits
    always_comb begin
        fold1 = {1'b0, i_rec.word_sum[15:0]} + {12'b0, i_rec.word_sum[20:16]};
        fold2 = fold1[15:0] + {15'b0, fold1[16]};
        if (i_rec.truncated) begin
            computed = '0;
            status   = STATUS_TRUNC;
        end else begin
            computed = ~fold2;
            status   = (computed == i_rec.checksum_stored) ? STATUS_OK : STATUS_FAIL;
        end
    end

    // Take the next queued frame whenever the output register is free or being drained
    assign o_rd_en = !i_q_status.empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rd_en) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_dmac     <= i_rec.dest_mac;
            r_smac     <= i_rec.source_mac;
            r_sip      <= i_rec.source_ip;
            r_dip      <= i_rec.dest_ip;
            r_hlen     <= i_rec.header_length;
            r_stored   <= i_rec.checksum_stored;
            r_computed <= computed;
            r_status   <= status;
        end
    end

    assign o_empty             = !r_valid;
    assign o_dest_mac          = r_dmac;
    assign o_source_mac        = r_smac;
    assign o_source_ip         = r_sip;
    assign o_dest_ip           = r_dip;
    assign o_header_length     = r_hlen;
    assign o_checksum_stored   = r_stored;
    assign o_checksum_computed = r_computed;
    assign o_status            = r_status;

endmodule

>>> rtl/ipv4_header_checksum_checker.sv
// Top level of the IPv4 header checksum checker: parser, frame queue and checksum stage.
// The block takes one Ethernet frame byte per clock while full is low and gives at most one
// transaction per frame: for an IPv4 frame of at least 34 bytes with an IHL of 5 or more, the
// MAC and IP addresses, header length, stored and computed checksums and a status (match,
// mismatch, or frame ended inside the header). A result is written into the frame queue when the
// final byte of its frame is accepted and moves on to the output register once that is free or
// being popped. Up to two finished frames queue behind the output register; full rises only when
// that queue is full, so the input stalls only if results go unpopped for three frames in a row.
module ipv4_header_checksum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [47:0] o_dest_mac,
    output logic [47:0] o_source_mac,
    output logic [31:0] o_source_ip,
    output logic [31:0] o_dest_ip,
    output logic [5:0]  o_header_length,
    output logic [15:0] o_checksum_stored,
    output logic [15:0] o_checksum_computed,
    output logic [1:0]  o_status
);
    import ihcc_pkg::*;

    logic      accept;
    logic      q_wr_en;
    logic      q_rd_en;
    t_record   q_wr_rec;
    t_record   q_rd_rec;
    t_q_status q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // Byte parser
    ihcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_wr_en      (q_wr_en),
        .o_rec        (q_wr_rec)
    );

    // Parsed frames waiting for the checksum stage
    ihcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (q_wr_en),
        .i_wr_rec (q_wr_rec),
        .i_rd_en  (q_rd_en),
        .o_rd_rec (q_rd_rec),
        .o_status (q_status)
    );

    // Checksum finish and result register
    ihcc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rec               (q_rd_rec),
        .i_q_status          (q_status),
        .o_rd_en             (q_rd_en),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_dest_mac          (o_dest_mac),
        .o_source_mac        (o_source_mac),
        .o_source_ip         (o_source_ip),
        .o_dest_ip           (o_dest_ip),
        .o_header_length     (o_header_length),
        .o_checksum_stored   (o_checksum_stored),
        .o_checksum_computed (o_checksum_computed),
        .o_status            (o_status)
    );

endmodule

>>> rtl/ihcc_checker.sv
// Port-level assertions for the IPv4 header checksum checker, bound to the top level.
module ihcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [5:0]  o_header_length,
    input logic [15:0] o_checksum_stored,
    input logic [15:0] o_checksum_computed,
    input logic [1:0]  o_status
);
    import ihcc_pkg::*;

    // A waiting result carries one of the three defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == STATUS_OK || o_status == STATUS_FAIL
                    || o_status == STATUS_TRUNC))
        else $error("result status outside the defined codes");

    // The status agrees with the two checksums it reports
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != STATUS_TRUNC)
        |-> ((o_status == STATUS_OK) == (o_checksum_stored == o_checksum_computed)))
        else $error("status disagrees with stored and computed checksums");

    // A truncated header reports no computed checksum
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STATUS_TRUNC) |-> (o_checksum_computed == 16'd0))
        else $error("truncated frame reports a computed checksum");

    // Only frames with a header of 20 bytes or more are reported
    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_header_length >= IP_MIN_HDR && o_header_length[1:0] == 2'b00))
        else $error("reported header length is not a valid IHL");

    // A result that is not popped stays on the ports
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_checksum_computed)))
        else $error("waiting result changed before it was popped");

endmodule

bind ipv4_header_checksum_checker ihcc_checker u_ihcc_checker (.*);
